### src/unix_seconds_calendar_converter_macros.svh
// Assertion macros used by the converter sequencer.
`ifndef UNIX_SECONDS_CALENDAR_CONVERTER_MACROS_SVH
`define UNIX_SECONDS_CALENDAR_CONVERTER_MACROS_SVH
`ifndef SYNTH
`define UCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define UCC_ASSERT(lbl, prop, msg)
`define UCC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### src/ucc_pkg.sv
// ----------------------------------------------------------------------------
// ucc_pkg
// Types, constants and table functions of the seconds/calendar converter.
// ----------------------------------------------------------------------------
package ucc_pkg;

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;
  localparam logic [16:0] DaysPerWeek = 17'd7;
  localparam logic [16:0] DaysPerYear = 17'd365;
  localparam logic [16:0] EpochDays   = 17'd25567;
  localparam logic [7:0]  Century     = 8'd100;
  localparam logic [7:0]  FirstYear   = 8'd70;

  typedef struct packed {
    logic        mode;
    logic [31:0] in_seconds;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_t;

  typedef struct packed {
    logic [31:0]       out_seconds;
    logic signed [7:0] out_year;
    logic [3:0]        out_month;
    logic [4:0]        out_day;
    logic [2:0]        out_weekday;
    logic [4:0]        out_hour;
    logic [5:0]        out_minute;
    logic [5:0]        out_second;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_GO, S_DIV_RUN, S_YFIX, S_MON, S_CAL1, S_CAL2, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_DAY, OP_HOUR, OP_MIN, OP_WDAY, OP_YEAR
  } op_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_latch;
    op_t  op;
    logic year_dec;
    logic year_take;
    logic mon_dec;
    logic cal1;
    logic cal2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic div_done;
    logic year_more;
    logic mon_more;
  } sts_t;

  // days from 1900-01-01 to Jan 1 of year y (y >= 1)
  function automatic logic [16:0] year_start(input logic [7:0] y);
    logic [16:0] prod;
    logic [7:0]  ym1;
    begin
      prod = 17'(y) * DaysPerYear;
      ym1  = y - 8'd1;
      return prod + 17'(ym1 >> 2);
    end
  endfunction

  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'd0) && (y != 8'd0);
  endfunction

  function automatic logic [8:0] month_off(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    begin
      unique case (idx)
        4'd0:  v = 9'd0;
        4'd1:  v = 9'd31;
        4'd2:  v = leap ? 9'd60  : 9'd59;
        4'd3:  v = leap ? 9'd91  : 9'd90;
        4'd4:  v = leap ? 9'd121 : 9'd120;
        4'd5:  v = leap ? 9'd152 : 9'd151;
        4'd6:  v = leap ? 9'd182 : 9'd181;
        4'd7:  v = leap ? 9'd213 : 9'd212;
        4'd8:  v = leap ? 9'd244 : 9'd243;
        4'd9:  v = leap ? 9'd274 : 9'd273;
        4'd10: v = leap ? 9'd305 : 9'd304;
        4'd11: v = leap ? 9'd335 : 9'd334;
        default: v = 9'd0;
      endcase
      return v;
    end
  endfunction

endpackage

### src/unix_seconds_calendar_converter.sv
// ----------------------------------------------------------------------------
// unix_seconds_calendar_converter
// Converts Unix seconds to calendar fields (mode 0) and back (mode 1).
// ----------------------------------------------------------------------------
// Usage: an item is taken on in_data when in_valid is high and in_stall low.
// in_stall is low only while the converter is idle; one item is worked at a
// time. The result goes to an output register and is shown with out_valid;
// it is taken at an edge where out_stall is low. A new item can be taken
// while a result still waits, but the next result is held back until the
// output register is free.
// Steps, mode 0: five constant divisions (route, capture, reciprocal
// multiply, remainder), a year correction, one to twelve steps of month
// search and a final load.
// Steps, mode 1: route, two arithmetic steps, load.
// An item is worked to its end before the next one is taken; a result
// that still waits holds the sequencer in its load step.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module unix_seconds_calendar_converter import ucc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  ucc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ucc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### src/ucc_div.sv
// ----------------------------------------------------------------------------
// ucc_div
// Constant divider: reciprocal multiply for the quotient, then remainder.
// ----------------------------------------------------------------------------
module ucc_div import ucc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  op_t         op,
  input  logic [31:0] dividend,
  output logic        done,
  output logic [31:0] quo,
  output logic [16:0] rem
);

  // q = (a * m) >> k, exact over the operand range of each step
  localparam logic [25:0] RecipDay  = 26'd50903317;  // (x >> 7) / 675, k = 35
  localparam logic [25:0] RecipHour = 26'd9321;      // (x >> 4) / 225, k = 21
  localparam logic [25:0] RecipMin  = 26'd1093;      // (x >> 2) / 15,  k = 14
  localparam logic [25:0] RecipWeek = 26'd149797;    // x / 7,           k = 20
  localparam logic [25:0] RecipYear = 26'd183860;    // x / 365,         k = 26

  op_t         op_r;
  logic [31:0] x;
  logic        step_mul;
  logic        step_back;
  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [16:0] dsr;
  logic [50:0] prod;
  logic [15:0] qt;
  logic [31:0] back;

  always_comb begin
    unique case (op_r)
      OP_DAY:  begin mul_a = x[31:7];       mul_b = RecipDay;  dsr = SecsPerDay;  end
      OP_HOUR: begin mul_a = 25'(x[16:4]);  mul_b = RecipHour; dsr = SecsPerHour; end
      OP_MIN:  begin mul_a = 25'(x[16:2]);  mul_b = RecipMin;  dsr = SecsPerMin;  end
      OP_WDAY: begin mul_a = 25'(x[16:0]);  mul_b = RecipWeek; dsr = DaysPerWeek; end
      OP_YEAR: begin mul_a = 25'(x[16:0]);  mul_b = RecipYear; dsr = DaysPerYear; end
      default: begin mul_a = '0;            mul_b = '0;        dsr = DaysPerYear; end
    endcase
  end

  assign prod = 51'(mul_a) * 51'(mul_b);

  always_comb begin
    unique case (op_r)
      OP_DAY:  qt = prod[50:35];
      OP_HOUR: qt = prod[36:21];
      OP_MIN:  qt = prod[29:14];
      OP_WDAY: qt = prod[35:20];
      OP_YEAR: qt = prod[41:26];
      default: qt = '0;
    endcase
  end

  assign back = 32'(quo[15:0]) * 32'(dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_mul  <= 1'b0;
      step_back <= 1'b0;
      done      <= 1'b0;
    end else begin
      step_mul  <= start;
      step_back <= step_mul;
      done      <= step_back;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= dividend;
      op_r <= op;
    end
    if (step_mul) quo <= 32'(qt);
    if (step_back) rem <= 17'(x - back);
  end

endmodule

### src/ucc_datapath.sv
// ----------------------------------------------------------------------------
// ucc_datapath
// Field registers, shared divider, year/month search and packing arithmetic.
// ----------------------------------------------------------------------------
module ucc_datapath import ucc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  in_t  in_data,
  output sts_t sts,
  output out_t out_data
);

  in_t         item;
  logic [16:0] days;
  logic [16:0] part;
  logic [7:0]  y;
  logic [3:0]  mon;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [2:0]  wday;
  logic [31:0] prod;

  logic [31:0] dvd;
  logic [31:0] q;
  logic [16:0] r;
  logic        done;
  logic [16:0] ys;
  logic [8:0]  off;
  logic [7:0]  y1;
  logic [3:0]  idx1;
  logic [16:0] days1;
  logic [16:0] part1;
  out_t        res;

  ucc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .op       (cmd.op),
    .dividend (dvd),
    .done     (done),
    .quo      (q),
    .rem      (r)
  );

  always_comb begin
    unique case (cmd.op)
      OP_DAY:  dvd = item.in_seconds;
      OP_HOUR: dvd = 32'(part);
      OP_MIN:  dvd = 32'(part);
      OP_WDAY: dvd = 32'(days + 17'd1);
      OP_YEAR: dvd = 32'(days);
      default: dvd = '0;
    endcase
  end

  assign ys  = year_start(y);
  assign off = month_off(is_leap(y), mon);

  // calendar to seconds: month 0 takes January, 13..15 take December
  assign y1 = 8'(item.year) + Century;
  always_comb begin
    if (item.month == 4'd0)       idx1 = 4'd0;
    else if (item.month > 4'd12)  idx1 = 4'd11;
    else                          idx1 = item.month - 4'd1;
  end
  assign days1 = year_start(y1) + 17'(month_off(is_leap(y1), idx1))
               + 17'(item.day_of_month) - (EpochDays + 17'd1);
  assign part1 = 17'(item.hour) * SecsPerHour + 17'(item.minute) * SecsPerMin
               + 17'(item.second);

  assign sts.mode      = item.mode;
  assign sts.div_done  = done;
  assign sts.year_more = (y > FirstYear) && (days < ys);
  assign sts.mon_more  = (mon != 4'd0) && (days < 17'(off));

  always_comb begin
    res = '0;
    if (item.mode) begin
      res.out_seconds = prod + 32'(part);
    end else begin
      res.out_year    = 8'(y - Century);
      res.out_month   = mon + 4'd1;
      res.out_day     = 5'(days - 17'(off) + 17'd1);
      res.out_weekday = wday;
      res.out_hour    = hour_r;
      res.out_minute  = min_r;
      res.out_second  = sec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.div_latch) begin
      unique case (cmd.op)
        OP_DAY:  begin days <= EpochDays + q[16:0]; part <= r; end
        OP_HOUR: begin hour_r <= q[4:0]; part <= r; end
        OP_MIN:  begin min_r <= q[5:0]; sec_r <= r[5:0]; end
        OP_WDAY: wday <= r[2:0];
        OP_YEAR: y <= q[7:0];
        default: ;
      endcase
    end
    if (cmd.year_dec) y <= y - 8'd1;
    if (cmd.year_take) begin
      days <= days - ys;
      mon  <= 4'd11;
    end
    if (cmd.mon_dec) mon <= mon - 4'd1;
    if (cmd.cal1) begin
      days <= days1;
      part <= part1;
    end
    // wraps modulo 2^32 like the seconds count itself
    if (cmd.cal2) prod <= 32'(days) * 32'(SecsPerDay);
    if (cmd.out_load) out_data <= res;
  end

endmodule

### src/ucc_ctrl.sv
// ----------------------------------------------------------------------------
// ucc_ctrl
// Sequencer: divide steps, year and month search, calendar-to-seconds steps, output register handshake.
// ----------------------------------------------------------------------------
`include "unix_seconds_calendar_converter_macros.svh"
module ucc_ctrl import ucc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  op_t    op, op_next;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      S_IDLE: if (accept) begin
        op_next    = OP_DAY;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        if (sts.mode) state_next = S_CAL1;
        else          state_next = S_DIV_RUN;
      end
      S_DIV_RUN: if (sts.div_done) begin
        if (op == OP_YEAR) begin
          state_next = S_YFIX;
        end else begin
          op_next    = op_t'(op + 3'd1);
          state_next = S_DIV_GO;
        end
      end
      S_YFIX:  if (!sts.year_more) state_next = S_MON;
      S_MON:   if (!sts.mon_more)  state_next = S_FIN;
      S_CAL1:  state_next = S_CAL2;
      S_CAL2:  state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = op;
    cmd.load      = accept;
    cmd.div_start = (state == S_DIV_GO) && !sts.mode;
    cmd.div_latch = (state == S_DIV_RUN) && sts.div_done;
    cmd.year_dec  = (state == S_YFIX) && sts.year_more;
    cmd.year_take = (state == S_YFIX) && !sts.year_more;
    cmd.mon_dec   = (state == S_MON) && sts.mon_more;
    cmd.cal1      = (state == S_CAL1);
    cmd.cal2      = (state == S_CAL2);
    cmd.out_load  = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_DAY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.out_load)    out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `UCC_ASSERT_IMP(a_done_in_run, sts.div_done, state == S_DIV_RUN, "divider done outside wait")
  `UCC_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid && out_stall), "result overwritten")
  `UCC_ASSERT(a_accept_leaves_idle, accept |=> state != S_IDLE, "accepted item dropped")
  `UCC_ASSERT(a_done_pulse, sts.div_done |=> !sts.div_done, "divider done longer than a cycle")

endmodule

### bench/tb_unix_seconds_calendar_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_calendar_converter
// Drives seconds-to-calendar and calendar-to-seconds items through the
// converter with random gaps and output stalls. Each result is checked
// field by field against a behavioral calendar model kept in this bench.
// ----------------------------------------------------------------------------
module tb_unix_seconds_calendar_converter import ucc_pkg::*;;

  localparam int unsigned CycleLimit = 1000000;
  localparam int          NumRandom  = 430;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  items_to_send[$];
  out_t calendar_expected[$];
  int   items_taken = 0;
  int   items_total = 0;
  int   mismatches = 0;
  int   send_gap = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;

  unix_seconds_calendar_converter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned days_to_year(int unsigned y);
    return (y - 1) / 4 + 365 * y;
  endfunction

  function automatic int unsigned month_start(int unsigned y, int unsigned idx);
    int unsigned plain[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned leapy[12] = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
    if ((y % 4) != 0 || y == 0) return plain[idx];
    return leapy[idx];
  endfunction

  // years are counted from 1900 internally
  function automatic out_t convert_time(in_t it);
    out_t        r;
    int unsigned days, rem, y, mon, idx, secs;
    r = '0;
    if (it.mode == 1'b0) begin
      days = 25567 + it.in_seconds / 86400;
      rem  = it.in_seconds % 86400;
      r.out_hour    = 5'(rem / 3600);
      rem = rem % 3600;
      r.out_minute  = 6'(rem / 60);
      r.out_second  = 6'(rem % 60);
      r.out_weekday = 3'((days + 1) % 7);
      y = days / 365;
      while (y > 70 && days < days_to_year(y)) y--;
      days = days - days_to_year(y);
      mon = 11;
      while (mon > 0 && days < month_start(y, mon)) mon--;
      r.out_year  = 8'(y + 256 - 100);
      r.out_month = 4'(mon + 1);
      r.out_day   = 5'(days - month_start(y, mon) + 1);
    end else begin
      y = it.year + 100;
      idx = (it.month == 0) ? 0 : ((it.month > 12) ? 11 : it.month - 1);
      days = days_to_year(y) + month_start(y, idx) - 1 + it.day_of_month - 25567;
      secs = 3600 * it.hour + 60 * it.minute + it.second + days * 86400;
      r.out_seconds = secs;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t make_cal(int unsigned y, int unsigned mo, int unsigned d,
                                   int unsigned h, int unsigned mi, int unsigned s);
    in_t it;
    it = in_t'({2'b00, $urandom, $urandom});
    it.mode = 1'b1;
    it.year = 7'(y); it.month = 4'(mo); it.day_of_month = 5'(d);
    it.hour = 5'(h); it.minute = 6'(mi); it.second = 6'(s);
    return it;
  endfunction

  function automatic in_t make_secs(int unsigned s);
    in_t it;
    it = in_t'({2'b00, $urandom, $urandom});
    it.mode = 1'b0;
    it.in_seconds = s;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        calendar_expected.push_back(convert_time(in_data));
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          in_data  <= items_to_send.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (calendar_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = calendar_expected.pop_front();
          if (out_data.out_seconds !== want.out_seconds || out_data.out_year !== want.out_year
              || out_data.out_month !== want.out_month || out_data.out_day !== want.out_day
              || out_data.out_weekday !== want.out_weekday
              || out_data.out_hour !== want.out_hour || out_data.out_minute !== want.out_minute
              || out_data.out_second !== want.out_second) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      out_stall <= (pick_gap() != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    // seconds to calendar: epoch, extremes, leap day, century edges
    items_to_send.push_back(make_secs(32'd0));
    items_to_send.push_back(make_secs(32'hFFFF_FFFF));
    items_to_send.push_back(make_secs(32'd86399));
    items_to_send.push_back(make_secs(32'd946684799));
    items_to_send.push_back(make_secs(32'd946684800));
    items_to_send.push_back(make_secs(32'd951782400));
    items_to_send.push_back(make_secs(32'd951868799));
    items_to_send.push_back(make_secs(32'd4107542400));
    items_to_send.push_back(make_secs(32'h8000_0000));
    // calendar to seconds
    items_to_send.push_back(make_cal(0, 1, 1, 0, 0, 0));
    items_to_send.push_back(make_cal(99, 12, 31, 23, 59, 59));
    items_to_send.push_back(make_cal(0, 2, 29, 12, 0, 0));
    items_to_send.push_back(make_cal(1, 3, 1, 0, 0, 0));
    // month out of range
    items_to_send.push_back(make_cal(5, 0, 10, 1, 2, 3));
    items_to_send.push_back(make_cal(5, 13, 10, 1, 2, 3));
    items_to_send.push_back(make_cal(8, 15, 31, 1, 2, 3));
    // impossible day and time
    items_to_send.push_back(make_cal(10, 2, 31, 0, 0, 0));
    items_to_send.push_back(make_cal(10, 6, 0, 31, 63, 63));
    // the sum wraps past 2106; the year-100 item still fits
    items_to_send.push_back(make_cal(106, 2, 7, 6, 28, 16));
    items_to_send.push_back(make_cal(127, 15, 31, 31, 63, 63));
    items_to_send.push_back(make_cal(100, 1, 1, 0, 0, 0));
    for (int i = 0; i < NumRandom; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) items_to_send.push_back(make_secs($urandom));
      else if (r < 85)
        items_to_send.push_back(make_cal($urandom_range(0, 99), $urandom_range(1, 12),
                                         $urandom_range(1, 28), $urandom_range(0, 23),
                                         $urandom_range(0, 59), $urandom_range(0, 59)));
      else
        items_to_send.push_back(make_cal($urandom_range(0, 127), $urandom_range(0, 15),
                                         $urandom_range(0, 31), $urandom_range(0, 31),
                                         $urandom_range(0, 63), $urandom_range(0, 63)));
    end
    items_total = items_to_send.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (items_taken == items_total && calendar_expected.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && calendar_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
